>>> design/mwg_pkg.sv
// shared types, codes and table function for the multichannel waveform generator
`default_nettype none

package mwg_pkg;

	localparam int CHAN_W  = 3;
	localparam int CFG_W   = 4;
	localparam int AMP_W   = 15;
	localparam int OFF_W   = 16;
	localparam int KIND_W  = 3;
	localparam int PHASE_W = 32;
	localparam int SMP_W   = 16;

	localparam logic       REQ_TICK = 1'b0;
	localparam logic       REQ_SET  = 1'b1;

	localparam logic [1:0] SEL_AMP  = 2'd0;
	localparam logic [1:0] SEL_INC  = 2'd1;
	localparam logic [1:0] SEL_OFF  = 2'd2;
	localparam logic [1:0] SEL_KIND = 2'd3;

	localparam logic [KIND_W-1:0] WAVE_SINE   = 3'd0;
	localparam logic [KIND_W-1:0] WAVE_SQUARE = 3'd1;
	localparam logic [KIND_W-1:0] WAVE_SAW    = 3'd2;
	localparam logic [KIND_W-1:0] WAVE_TRI    = 3'd3;
	localparam logic [KIND_W-1:0] WAVE_NOISE  = 3'd4;

	localparam logic REG_CHANNELS_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;
	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

	localparam logic [AMP_W-1:0] AMP_RESET = 15'd100;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [PHASE_W-1:0] inc;
		logic [AMP_W-1:0]   amp;
		logic [OFF_W-1:0]   off;
		logic [KIND_W-1:0]  kind;
	} set_word_t;

	localparam set_word_t SET_RESET = '{inc: '0, amp: AMP_RESET, off: '0, kind: WAVE_SINE};

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_TICK = 3'b010,
		ST_SET  = 3'b100
	} seq_state_t;

	// quarter-wave sine entry k for a table of 2^b steps, taylor series to x^13 in q30
	function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned b);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		logic [63:0] v;
		x    = (64'(k) * HALF_PI_Q30) >> b;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[14:0];
	endfunction

endpackage

`default_nettype wire

>>> design/mwg_state_mem.sv
// per-channel accumulator and settings memories with valid bits standing in for reset
`default_nettype none

module mwg_state_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	input  wire logic              acc_wr_en,
	input  wire logic [AW-1:0]     acc_wr_addr,
	input  wire logic [31:0]       acc_wr_data,
	input  wire logic              set_wr_en,
	input  wire logic [AW-1:0]     set_wr_addr,
	input  wire mwg_pkg::set_word_t set_wr_data,
	output logic [31:0]            acc_rd_data,
	output mwg_pkg::set_word_t     set_rd_data
);
	import mwg_pkg::*;

	logic [31:0]      acc_mem [DEPTH];
	set_word_t        set_mem [DEPTH];
	logic [DEPTH-1:0] acc_vld_q;
	logic [DEPTH-1:0] set_vld_q;
	logic [31:0]      acc_rd_q;
	set_word_t        set_rd_q;
	logic             acc_hit_q;
	logic             set_hit_q;

	always_ff @(posedge clk) begin
		if (acc_wr_en) begin
			acc_mem[acc_wr_addr] <= acc_wr_data;
		end
		if (set_wr_en) begin
			set_mem[set_wr_addr] <= set_wr_data;
		end
		if (rd_en) begin
			acc_rd_q <= acc_mem[rd_addr];
			set_rd_q <= set_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
			set_vld_q <= '0;
			acc_hit_q <= 1'b0;
			set_hit_q <= 1'b0;
		end else begin
			if (acc_wr_en) begin
				acc_vld_q[acc_wr_addr] <= 1'b1;
			end
			if (set_wr_en) begin
				set_vld_q[set_wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				acc_hit_q <= acc_vld_q[rd_addr];
				set_hit_q <= set_vld_q[rd_addr];
			end
		end
	end

	// never-written entries read as their reset values
	assign acc_rd_data = acc_hit_q ? acc_rd_q : '0;
	assign set_rd_data = set_hit_q ? set_rd_q : SET_RESET;

endmodule

`default_nettype wire

>>> design/mwg_sine_rom.sv
// quarter-wave sine rom with registered read
`default_nettype none

module mwg_sine_rom #(
	parameter int TABLE_BITS = 10
) (
	input  wire logic                clk,
	input  wire logic                rd_en,
	input  wire logic [TABLE_BITS:0] rd_addr,
	output logic [14:0]              rd_data
);
	import mwg_pkg::*;

	localparam int LEN = (1 << TABLE_BITS) + 1;

	typedef logic [14:0] rom_t [LEN];

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k < LEN; k++) begin
			r[k] = sine_entry(k, TABLE_BITS);
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [14:0] data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= ROM[rd_addr];
		end
	end

	assign rd_data = data_q;

endmodule

`default_nettype wire

>>> design/mwg_shaper.sv
// waveform lookup, noise lfsr and amplitude scaling, ending in the output register
`default_nettype none

module mwg_shaper #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       v_s2,
	input  wire logic [31:0]                p_s2,
	input  wire logic [mwg_pkg::KIND_W-1:0] kind_s2,
	input  wire logic [mwg_pkg::AMP_W-1:0]  amp_s2,
	input  wire logic [mwg_pkg::CHAN_W-1:0] ch_s2,
	input  wire logic                       last_s2,
	output logic                            out_valid,
	output logic [mwg_pkg::CHAN_W-1:0]      out_channel,
	output logic signed [mwg_pkg::SMP_W-1:0] sample,
	output logic                            last
);
	import mwg_pkg::*;

	localparam logic [SINE_TABLE_BITS:0] ROM_FULL = {1'b1, {SINE_TABLE_BITS{1'b0}}};

	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [SINE_TABLE_BITS:0]   rom_addr;
	logic [14:0]                rom_data;
	logic [15:0]                s;
	logic signed [17:0]         tri_v;
	logic [31:0]                lfsr_q;
	logic [31:0]                lfsr_nxt;
	logic signed [SMP_W-1:0]    noise_w;
	logic signed [SMP_W-1:0]    wave;

	logic                       v_s3;
	logic                       is_sine_s3;
	logic                       neg_s3;
	logic signed [SMP_W-1:0]    wave_s3;
	logic [AMP_W-1:0]           amp_s3;
	logic [CHAN_W-1:0]          ch_s3;
	logic                       last_s3;
	logic signed [SMP_W-1:0]    w_sel;
	logic signed [31:0]         prod;

	logic                       out_v_q;
	logic [CHAN_W-1:0]          out_ch_q;
	logic signed [SMP_W-1:0]    sample_q;
	logic                       last_q;

	assign quad     = p_s2[31:30];
	assign idx      = p_s2[29 -: SINE_TABLE_BITS];
	assign rom_addr = quad[0] ? (ROM_FULL - {1'b0, idx}) : {1'b0, idx};
	assign s        = p_s2[31:16];

	mwg_sine_rom #(
		.TABLE_BITS(SINE_TABLE_BITS)
	) u_rom (
		.clk    (clk),
		.rd_en  (en),
		.rd_addr(rom_addr),
		.rd_data(rom_data)
	);

	// galois step, right shift
	assign lfsr_nxt = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
	assign noise_w  = $signed({1'b0, lfsr_nxt[15:1]}) - 16'sd16384;

	always_comb begin
		if (!s[15]) begin
			tri_v = $signed({1'b0, s, 1'b0}) - 18'sd32768;
		end else begin
			tri_v = 18'sd98303 - $signed({1'b0, s, 1'b0});
		end
	end

	always_comb begin
		case (kind_s2)
			WAVE_SINE:   wave = '0;
			WAVE_SQUARE: wave = p_s2[31] ? -16'sd32767 : 16'sd32767;
			WAVE_SAW:    wave = $signed({~s[15], s[14:0]});
			WAVE_TRI:    wave = tri_v[15:0];
			WAVE_NOISE:  wave = noise_w;
			default:     wave = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q  <= LFSR_SEED;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			if (v_s2 && kind_s2 == WAVE_NOISE) begin
				lfsr_q <= lfsr_nxt;
			end
			v_s3    <= v_s2;
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			is_sine_s3 <= (kind_s2 == WAVE_SINE);
			neg_s3     <= quad[1];
			wave_s3    <= wave;
			amp_s3     <= amp_s2;
			ch_s3      <= ch_s2;
			last_s3    <= last_s2;
		end
	end

	always_comb begin
		if (is_sine_s3) begin
			w_sel = neg_s3 ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
		end else begin
			w_sel = wave_s3;
		end
	end

	// floor of the product over 2^15 for either sign
	assign prod = $signed({1'b0, amp_s3}) * w_sel;

	always_ff @(posedge clk) begin
		if (en) begin
			sample_q <= prod[30:15];
			out_ch_q <= ch_s3;
			last_q   <= last_s3;
		end
	end

	assign out_valid   = out_v_q;
	assign out_channel = out_ch_q;
	assign sample      = sample_q;
	assign last        = last_q;

endmodule

`default_nettype wire

>>> design/multichannel_waveform_generator.sv
// After acceptance a tick runs through the sequencer state, s1, s2, s3 and output register,
// then gives one sample per cycle while the output is not stalled. A tick holds the
// input until the accumulator read-modify-write of the last of its n active channels.
// Output stall freezes the whole pipeline. Reset clears control, the lfsr (0xACE1) and
// channels_in_use (8); memory entries read as reset values until first written, no sweep.
`default_nettype none

module multichannel_waveform_generator #(
	parameter int CHANNELS        = 8,
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [2:0]                  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        req_type,
	input  wire logic [mwg_pkg::CHAN_W-1:0]  channel,
	input  wire logic [1:0]                  setting_select,
	input  wire logic [31:0]                 setting_value,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [mwg_pkg::CHAN_W-1:0]       out_channel,
	output logic signed [mwg_pkg::SMP_W-1:0] sample,
	output logic                             last
);
	import mwg_pkg::*;

	localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MAX_CH = (CHANNELS < 8) ? CHANNELS : 8;

	logic [CFG_W-1:0]  cfg_q;
	logic              cfg_wr;
	seq_state_t        state_q;
	logic [CHAN_W-1:0] ch_q;
	logic [1:0]        sel_q;
	logic [31:0]       val_q;
	logic [CFG_W-1:0]  n_eff;
	logic [CHAN_W-1:0] first_ch;
	logic              in_acc;
	logic              en;
	logic              issue;

	logic              v_s1;
	logic              tick_s1;
	logic [CHAN_W-1:0] ch_s1;
	logic              last_s1;
	logic [31:0]       acc_rd;
	set_word_t         set_rd;
	logic [31:0]       p_s1;
	logic              acc_wr_en;
	logic              set_wr_en;
	logic              in_range;
	set_word_t         set_new;

	logic              v_s2;
	logic [31:0]       p_s2;
	logic [KIND_W-1:0] kind_s2;
	logic [AMP_W-1:0]  amp_s2;
	logic [CHAN_W-1:0] ch_s2;
	logic              last_s2;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_CHANNELS_IN_USE);
	assign prdata = (paddr[2] == REG_CHANNELS_IN_USE) ? 32'(cfg_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			cfg_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		if (cfg_q == '0) begin
			n_eff = CFG_W'(1);
		end else if (cfg_q > CFG_W'(MAX_CH)) begin
			n_eff = CFG_W'(MAX_CH);
		end else begin
			n_eff = cfg_q;
		end
	end
	assign first_ch = CHAN_W'(n_eff - CFG_W'(1));

	// pipeline advances unless a finished sample is held
	assign en       = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || v_s1;
	assign in_acc   = in_valid && !in_stall;
	assign issue    = en && (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (req_type == REQ_SET) ? ST_SET : ST_TICK;
						ch_q    <= (req_type == REQ_SET) ? channel : first_ch;
					end
				end
				ST_TICK: begin
					if (en) begin
						if (ch_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q <= ch_q - CHAN_W'(1);
						end
					end
				end
				ST_SET: begin
					if (en) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sel_q <= setting_select;
			val_q <= setting_value;
		end
	end

	// s1: memory read data arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			tick_s1 <= 1'b0;
		end else if (en) begin
			v_s1    <= issue;
			tick_s1 <= (state_q == ST_TICK);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ch_s1   <= ch_q;
			last_s1 <= (ch_q == '0);
		end
	end

	mwg_state_mem #(
		.DEPTH(CHANNELS),
		.AW   (AW)
	) u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (issue),
		.rd_addr    (AW'(ch_q)),
		.acc_wr_en  (acc_wr_en),
		.acc_wr_addr(AW'(ch_s1)),
		.acc_wr_data(acc_rd + set_rd.inc),
		.set_wr_en  (set_wr_en),
		.set_wr_addr(AW'(ch_s1)),
		.set_wr_data(set_new),
		.acc_rd_data(acc_rd),
		.set_rd_data(set_rd)
	);

	assign p_s1      = acc_rd + {set_rd.off, 16'h0000};
	assign in_range  = (7'(ch_s1) < 7'(CHANNELS));
	assign acc_wr_en = en && v_s1 && tick_s1;
	assign set_wr_en = en && v_s1 && !tick_s1 && in_range;

	always_comb begin
		set_new = set_rd;
		case (sel_q)
			SEL_AMP:  set_new.amp  = val_q[AMP_W-1:0];
			SEL_INC:  set_new.inc  = val_q;
			SEL_OFF:  set_new.off  = val_q[OFF_W-1:0];
			SEL_KIND: set_new.kind = val_q[KIND_W-1:0];
			default:  set_new = set_rd;
		endcase
	end

	// s2: phase ready for the shaper
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && tick_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2    <= p_s1;
			kind_s2 <= set_rd.kind;
			amp_s2  <= set_rd.amp;
			ch_s2   <= ch_s1;
			last_s2 <= last_s1;
		end
	end

	mwg_shaper #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_shaper (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.v_s2       (v_s2),
		.p_s2       (p_s2),
		.kind_s2    (kind_s2),
		.amp_s2     (amp_s2),
		.ch_s2      (ch_s2),
		.last_s2    (last_s2),
		.out_valid  (out_valid),
		.out_channel(out_channel),
		.sample     (sample),
		.last       (last)
	);

`ifndef SYNTHESIS
	a_last_is_ch0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_channel == '0)
		else $error("last beat not on channel 0");

	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && req_type == REQ_TICK |=> state_q == ST_TICK && ch_q == $past(first_ch))
		else $error("tick did not start at the top active channel");

	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TICK && en && ch_q != '0 |=>
			state_q == ST_TICK && ch_q == CHAN_W'($past(ch_q) - CHAN_W'(1)))
		else $error("channel sweep skipped or stalled wrongly");
`endif

endmodule

`default_nettype wire
